[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

[rtl/core/btdd_pkg.sv]
// Types, constants and codes for the binary to decimal digits converter.
package btdd_pkg;

    localparam logic       OP_ASCII   = 1'b0;
    localparam logic       OP_PACKED  = 1'b1;

    localparam logic [4:0] MAX_LEN    = 5'd16;
    localparam logic [3:0] ASC_UNITS  = 4'd10;
    localparam logic [3:0] BCD_UNITS  = 4'd5;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] PACK_PAD   = 8'h00;

    localparam int BIN_W         = 32;
    localparam int BCD_W         = 40;
    localparam int BITS_PER_STEP = 4;
    localparam int CONV_STEPS    = BIN_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(CONV_STEPS);

    typedef struct packed {
        logic [31:0] value;
        logic [4:0]  out_length;
        logic        opcode;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic left_zero;
        logic left_one;
    } t_dp_status;

endpackage

[rtl/core/btdd_ctrl.sv]
// Controller: sequences accept, conversion steps and byte emission.
module btdd_ctrl
    import btdd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } t_state;

    t_state              r_state;
    logic [STEP_W-1:0]   r_step;
    logic                r_out_valid;
    logic                emit_fire;

    // A byte may load when the output register is empty or being drained.
    assign emit_fire   = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);
    // Hold off input items while in reset or busy.
    assign o_in_stall  = !i_rst_n || (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd      = '0;
        o_cmd.load = (r_state == S_IDLE) && i_in_valid;
        o_cmd.step = (r_state == S_CONV);
        o_cmd.emit = emit_fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_step <= '0;
                    if (i_in_valid) begin
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(CONV_STEPS - 1)) begin
                        // zero length: nothing to emit
                        r_state <= i_status.left_zero ? S_IDLE : S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (emit_fire && i_status.left_one) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/core/btdd_dp.sv]
// Datapath: shift-add-3 conversion, byte selection and output register.
module btdd_dp
    import btdd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_item   i_in_item,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output t_out_item  o_out_item
);

    logic [BIN_W-1:0] r_bin;
    logic [BCD_W-1:0] r_bcd;
    logic [4:0]       r_left;
    logic [5:0]       r_pos;
    logic             r_mode;
    t_out_item        r_out;

    logic [4:0]             len_sat;
    logic [3:0]             units;
    logic [BCD_W+BIN_W-1:0] dabbled;
    logic [3:0]             idx;
    logic [5:0]             asc_sh;
    logic [6:0]             pk_sh;
    logic [7:0]             sel_byte;

    // Apply BITS_PER_STEP shift-add-3 steps to the joined digit and binary word.
    function automatic logic [BCD_W+BIN_W-1:0] dabble(input logic [BCD_W+BIN_W-1:0] v);
        logic [BCD_W+BIN_W-1:0] w;
        w = v;
        for (int s = 0; s < BITS_PER_STEP; s++) begin
            for (int d = 0; d < BCD_W / 4; d++) begin
                if (w[BIN_W + 4*d +: 4] >= 4'd5) begin
                    w[BIN_W + 4*d +: 4] = w[BIN_W + 4*d +: 4] + 4'd3;
                end
            end
            w = w << 1;
        end
        return w;
    endfunction

    assign len_sat = (i_in_item.out_length > MAX_LEN) ? MAX_LEN : i_in_item.out_length;
    assign units   = (i_in_item.opcode == OP_PACKED) ? BCD_UNITS : ASC_UNITS;
    assign dabbled = dabble({r_bcd, r_bin});

    // Position counts from the most significant digit; negative means pad.
    assign idx    = r_pos[3:0];
    assign asc_sh = {ASC_UNITS - 4'd1 - idx, 2'b00};
    assign pk_sh  = {BCD_UNITS - 4'd1 - idx, 3'b000};

    always_comb begin
        if (r_pos[5]) begin
            sel_byte = (r_mode == OP_PACKED) ? PACK_PAD : ASCII_ZERO;
        end else if (r_mode == OP_PACKED) begin
            sel_byte = 8'(r_bcd >> pk_sh);
        end else begin
            sel_byte = ASCII_ZERO | {4'd0, 4'(r_bcd >> asc_sh)};
        end
    end

    assign o_status.left_zero = (r_left == 5'd0);
    assign o_status.left_one  = (r_left == 5'd1);
    assign o_out_item         = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin  <= '0;
            r_left <= '0;
            r_pos  <= '0;
            r_mode <= OP_ASCII;
            r_bcd  <= '0;
        end else if (i_cmd.load) begin
            r_bin  <= i_in_item.value;
            r_bcd  <= '0;
            r_left <= len_sat;
            r_mode <= i_in_item.opcode;
            r_pos  <= {2'b00, units} - {1'b0, len_sat};
        end else if (i_cmd.step) begin
            r_bcd <= dabbled[BIN_W +: BCD_W];
            r_bin <= dabbled[BIN_W-1:0];
        end else if (i_cmd.emit) begin
            r_left <= r_left - 5'd1;
            r_pos  <= r_pos + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.out_byte <= sel_byte;
            r_out.last     <= (r_left == 5'd1);
        end
    end

endmodule

[rtl/core/binary_to_decimal_digits.sv]
// Channel   Direction  Payload      Handshake
// in        input      t_in_item    i_in_valid / o_in_stall
// out       output     t_out_item   o_out_valid / i_out_stall
//
// An item is accepted, then converted four bits per cycle through the
// shift-add-3 datapath, then emitted one output byte at a time.
// Output stalls hold the output register and pause byte emission.
// A new item is taken while the final byte still waits in the output register.
// Reset is synchronous and active low; it idles the controller.
module binary_to_decimal_digits
    import btdd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_dp_cmd    cmd;
    t_dp_status status;

    btdd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    btdd_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_item (o_out_item)
    );

endmodule

[rtl/core/btdd_checker.sv]
// Port-level checks for the converter, bound to the top level.
`include "assert_macros.svh"

module btdd_checker
    import btdd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    `ASSERT_NEXT(a_out_valid_holds, o_out_valid && i_out_stall, o_out_valid, "item dropped")
    `ASSERT_NEXT(a_out_item_holds, o_out_valid && i_out_stall, $stable(o_out_item), "item changed")
    `ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "input not held off")
    `ASSERT_CLK(a_out_when_busy, $rose(o_out_valid) |-> $past(o_in_stall), "item without work")

endmodule

bind binary_to_decimal_digits btdd_checker u_btdd_checker (.*);
